// ===== rtl/core/tdp_pkg.sv =====
package tdp_pkg;

  // Status that the remainder unit reports back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// ===== rtl/core/tdp_rem_unit.sv =====
module tdp_rem_unit import tdp_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output rem_status_t      status,
  output logic             rem_zero
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] shreg;
  logic [WIDTH-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // One restoring step a cycle: bring down the next dividend bit, then
  // subtract the divisor if it fits.
  assign trial = {rem, shreg[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(WIDTH);
        rem   <= '0;
        shreg <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        shreg <= shreg << 1;
        if (diff[WIDTH]) begin
          rem <= trial[WIDTH-1:0];
        end else begin
          rem <= diff[WIDTH-1:0];
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign rem_zero    = (rem == '0);

endmodule

// ===== rtl/core/trial_division_prime_test_unit.sv =====
// Trial-division primality test, one number at a time.
// Even numbers and numbers below 3 are settled in S_CHECK; odd n >= 3 are tried against odd
// divisors d = 3, 5, ... while d * d <= n, each trial passing through S_BOUND (bound check and
// remainder start) and S_DIV (bit-serial remainder unit); the result goes out from S_FINISH.
// A new number is taken only when the previous result has gone to the output register.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module trial_division_prime_test_unit import tdp_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] n,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_prime
);

  localparam int SW = WIDTH + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_BOUND  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state;
  logic [WIDTH-1:0] n_reg;
  logic [WIDTH-1:0] d;
  logic [SW-1:0]    sq;
  logic             res;
  logic             div_start;
  rem_status_t      div_status;
  logic             div_zero;

  tdp_rem_unit #(.WIDTH(WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n_reg),
    .divisor  (d),
    .status   (div_status),
    .rem_zero (div_zero)
  );

  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_BOUND) && (sq <= {2'b00, n_reg});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_FINISH the output register is reloaded instead of cleared.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n_reg <= n;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_reg < WIDTH'(2)) begin
            res   <= 1'b0;
            state <= S_FINISH;
          end else if (n_reg == WIDTH'(2)) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else if (!n_reg[0]) begin
            res   <= 1'b0;
            state <= S_FINISH;
          end else begin
            d     <= WIDTH'(3);
            sq    <= SW'(9);
            state <= S_BOUND;
          end
        end
        S_BOUND: begin
          // The running square of d is kept exact, so the bound never wraps.
          if (div_start) begin
            state <= S_DIV;
          end else begin
            res   <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            if (div_zero) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              // (d + 2)^2 = d^2 + 4d + 4
              d     <= d + WIDTH'(2);
              sq    <= sq + {d, 2'b00} + SW'(4);
              state <= S_BOUND;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            is_prime  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/trial_division_prime_test_unit_test.sv =====
`timescale 1ns / 100ps

module trial_division_prime_test_unit_test;

  localparam int WIDTH = 31;
  localparam logic [WIDTH-1:0] N_MAX = {WIDTH{1'b1}};

  typedef struct {
    logic [WIDTH-1:0] n;
    logic             prime;
  } primality_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [WIDTH-1:0] n = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             is_prime;

  primality_t pending_answers[$];
  int         mismatch_count = 0;
  int         numbers_sent = 0;
  int         answers_checked = 0;
  int         primes_seen = 0;
  longint     cycle_count = 0;
  longint     hold_until = 0;
  bit         no_gaps = 1'b0;

  trial_division_prime_test_unit #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .n(n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_prime(is_prime)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("trial_division_prime_test_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Odd divisors from 3 while d * d <= v; the bound is kept as d <= v / d.
  function automatic logic prime_by_division(input logic [WIDTH-1:0] v);
    longint unsigned value;
    longint unsigned d;
    value = 64'(v);
    if (value < 2) return 1'b0;
    if (value == 2) return 1'b1;
    if (value[0] == 1'b0) return 1'b0;
    for (d = 3; d <= value / d; d += 2) begin
      if (value % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result side: check each transfer against the oldest pending answer, then
  // decide whether to accept in the next cycle.
  always @(posedge clk) begin
    primality_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: is_prime = %0d", is_prime);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (is_prime) primes_seen++;
        if (is_prime !== want.prime) begin
          $error("is_prime mismatch for n = %0d: expected %0d, actual %0d",
                 want.n, want.prime, is_prime);
          mismatch_count++;
        end
      end
    end
    if (rst || cycle_count < hold_until) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_number(input logic [WIDTH-1:0] value);
    primality_t item;
    int gap;
    if (!no_gaps && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    n <= value;
    do @(posedge clk); while (!in_ready);
    item.n = value;
    item.prime = prime_by_division(value);
    pending_answers.push_back(item);
    numbers_sent++;
  endtask

  // A large number that is sure to have a small factor, so it finishes fast.
  function automatic logic [WIDTH-1:0] large_with_small_factor();
    longint unsigned p;
    longint unsigned m;
    p = 64'(2 * $urandom_range(1, 20) + 1);
    m = 64'($urandom_range(1, int'(N_MAX / p)));
    return WIDTH'(p * m);
  endfunction

  task automatic test_small_cases();
    send_number(WIDTH'(0));
    send_number(WIDTH'(1));
    send_number(WIDTH'(2));
    send_number(WIDTH'(3));
    send_number(WIDTH'(4));
    send_number(WIDTH'(5));
    // Squares of primes hit the divisor bound exactly.
    send_number(WIDTH'(9));
    send_number(WIDTH'(25));
    send_number(WIDTH'(49));
    send_number(WIDTH'(63001));
    send_number(WIDTH'(65537));
    send_number(WIDTH'(1000003));
  endtask

  task automatic test_top_of_range();
    send_number(N_MAX);
    send_number(N_MAX - WIDTH'(1));
    send_number(N_MAX - WIDTH'(2));
    send_number(WIDTH'(31'h5555_5555));
    send_number(WIDTH'(31'h2AAA_AAAA));
    send_number(WIDTH'(1) << (WIDTH - 1));
  endtask

  task automatic test_random_mix();
    int pick;
    logic [WIDTH-1:0] value;
    for (int i = 0; i < 70; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        value = WIDTH'($urandom_range(0, 4095));
      end else if (pick < 75) begin
        value = WIDTH'($urandom_range(0, 1 << 20));
      end else if (pick < 88) begin
        value = large_with_small_factor();
      end else begin
        value = WIDTH'($urandom) & ~WIDTH'(1);
      end
      send_number(value);
    end
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_number(WIDTH'($urandom_range(0, 2047)));
    end
    no_gaps = 1'b0;
  endtask

  // The result side holds off while numbers keep coming, so the block has to
  // stall its input until the held result goes out.
  task automatic test_output_stall();
    hold_until = cycle_count + 400;
    for (int i = 0; i < 6; i++) begin
      send_number(WIDTH'($urandom_range(0, 1023)));
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d of %0d numbers (%0d prime): small cases, top of range,",
             answers_checked, numbers_sent, primes_seen);
    $display("random mix, back-to-back transfers and a long result stall.");
    if (mismatch_count == 0) begin
      $display("trial_division_prime_test_unit regression: pass");
    end else begin
      $display("trial_division_prime_test_unit regression: fail");
    end
    $finish;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_cases();
    test_top_of_range();
    test_output_stall();
    test_random_mix();
    test_back_to_back();
    finish_run();
  end

endmodule

// ===== sim.f =====
rtl/core/tdp_pkg.sv
rtl/core/tdp_rem_unit.sv
rtl/core/trial_division_prime_test_unit.sv
tb/trial_division_prime_test_unit_test.sv
